// ===== sv/bpf_pkg.sv =====
// Package: shared types and constants of the Bezier path flattener.
`timescale 1ns / 1ps
package bpf_pkg;

  localparam int COORD_W   = 24;
  localparam int MAX_DEPTH = 6;
  localparam int TOL_W     = 16;
  localparam int EPS_W     = 8;
  localparam int CFG_W     = 16;
  localparam int LVL_W     = 3;

  // Command opcodes
  localparam logic [2:0] OP_MOVE  = 3'd0;
  localparam logic [2:0] OP_LINE  = 3'd1;
  localparam logic [2:0] OP_QUAD  = 3'd2;
  localparam logic [2:0] OP_CUBIC = 3'd3;
  localparam logic [2:0] OP_CLOSE = 3'd4;

  // Configuration register indexes
  localparam logic CFG_TOLERANCE = 1'b0;
  localparam logic CFG_EPSILON   = 1'b1;

  typedef struct packed {
    logic        [2:0]         opcode;
    logic signed [COORD_W-1:0] p1_x;
    logic signed [COORD_W-1:0] p1_y;
    logic signed [COORD_W-1:0] p2_x;
    logic signed [COORD_W-1:0] p2_y;
    logic signed [COORD_W-1:0] p3_x;
    logic signed [COORD_W-1:0] p3_y;
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last;
    logic                      error;
  } vtx_t;

endpackage

// ===== sv/bezier_path_flattener_unit.sv =====
// Top level: path command flattener with one shared multiply-accumulate unit.
`timescale 1ns / 1ps
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------
//  in      | input     | in_valid_i / in_ready_o   | in_data_i  (cmd_t)
//  out     | output    | out_valid_o / out_ready_i | out_data_o (vtx_t)
//  cfg     | input     | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
//  Move, error and unknown commands bypass the MAC; a line or close passes
//  ST_TOL, ST_EPS, ST_CH0, ST_CH1 and ST_DECIDE. Each curve piece squares its
//  chord, then tests its control points in turn (dot product if degenerate, else
//  cross product and tolerance compare), all through the single MAC, and passes ST_POP when popped off the stack.
//  Reset clears the current point, the started flag and all control state.
//  A full output register with a vertex already held stalls the sequencer.
module bezier_path_flattener_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bpf_pkg::cmd_t        in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bpf_pkg::vtx_t        out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [bpf_pkg::CFG_W-1:0] cfg_data_i
);
  import bpf_pkg::*;

  localparam int ACC_W  = 104;
  localparam int OPD_W  = 33;
  localparam int PRD_W  = 2 * OPD_W;
  localparam int CH_W   = 51;
  localparam int SP_W   = 3;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_TOL    = 4'd1;
  localparam logic [3:0] ST_EPS    = 4'd2;
  localparam logic [3:0] ST_CH0    = 4'd3;
  localparam logic [3:0] ST_CH1    = 4'd4;
  localparam logic [3:0] ST_PT0    = 4'd5;
  localparam logic [3:0] ST_PT1    = 4'd6;
  localparam logic [3:0] ST_C0     = 4'd7;
  localparam logic [3:0] ST_C1     = 4'd8;
  localparam logic [3:0] ST_C2     = 4'd9;
  localparam logic [3:0] ST_C3     = 4'd10;
  localparam logic [3:0] ST_C4     = 4'd11;
  localparam logic [3:0] ST_DECIDE = 4'd12;
  localparam logic [3:0] ST_POP    = 4'd13;
  localparam logic [3:0] ST_DONE   = 4'd14;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_26 = 2'd1;
  localparam logic [1:0] SH_27 = 2'd2;
  localparam logic [1:0] SH_52 = 2'd3;

  typedef logic signed [COORD_W-1:0] crd_t;

  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    crd_t [3:0]       x;
    crd_t [3:0]       y;
  } row_t;

  // Control registers
  logic [3:0]       state_q, state_d;
  logic             started_q;
  logic [SP_W-1:0]  sp_q;
  logic [LVL_W-1:0] lvl_q;
  logic [1:0]       e_q;
  logic             pidx_q;
  logic             flat_q;
  logic             deg_q;
  logic             hold_v_q;
  logic             out_valid_q;

  // Payload registers
  logic [TOL_W-1:0] tol_q;
  logic [EPS_W-1:0] eps_q;
  crd_t             cur_x_q, cur_y_q, sub_x_q, sub_y_q;
  crd_t [3:0]       qx_q, qy_q;
  logic [31:0]      tol2_q;
  logic [15:0]      eps2_q;
  logic [CH_W-1:0]  chord2_q;
  logic [CH_W-1:0]  c_q;
  logic signed [ACC_W-1:0] acc_q;
  vtx_t             hold_q, out_q;
  row_t             stack_mem [2**SP_W];
  row_t             rd_q;

  // Shared multiply-accumulate unit
  logic signed [OPD_W-1:0] ma, mb;
  logic signed [PRD_W-1:0] prod;
  logic signed [ACC_W-1:0] pext, pshift, acc_d;
  logic [1:0]              sh;
  logic                    clr, sub;

  // Geometry differences
  crd_t                    qe_x, qe_y, qp_x, qp_y;
  logic signed [COORD_W:0] ex, ey, wx, wy;
  logic [TOL_W-1:0]        tol_eff;

  always_comb begin
    case (e_q)
      2'd1:    begin qe_x = qx_q[1]; qe_y = qy_q[1]; end
      2'd2:    begin qe_x = qx_q[2]; qe_y = qy_q[2]; end
      default: begin qe_x = qx_q[3]; qe_y = qy_q[3]; end
    endcase
    qp_x = pidx_q ? qx_q[2] : qx_q[1];
    qp_y = pidx_q ? qy_q[2] : qy_q[1];
    ex = {qe_x[COORD_W-1], qe_x} - {qx_q[0][COORD_W-1], qx_q[0]};
    ey = {qe_y[COORD_W-1], qe_y} - {qy_q[0][COORD_W-1], qy_q[0]};
    wx = {qp_x[COORD_W-1], qp_x} - {qx_q[0][COORD_W-1], qx_q[0]};
    wy = {qp_y[COORD_W-1], qp_y} - {qy_q[0][COORD_W-1], qy_q[0]};
    tol_eff = (tol_q == '0) ? TOL_W'(1) : tol_q;
  end

  // Select MAC operands per sequencer step
  always_comb begin
    ma  = '0;
    mb  = '0;
    sh  = SH_0;
    clr = 1'b1;
    sub = 1'b0;
    case (state_q)
      ST_TOL: begin
        ma = OPD_W'(tol_eff); mb = OPD_W'(tol_eff);
      end
      ST_EPS: begin
        ma = OPD_W'(eps_q); mb = OPD_W'(eps_q);
      end
      ST_CH0: begin
        ma = OPD_W'(ex); mb = OPD_W'(ex);
      end
      ST_CH1: begin
        ma = OPD_W'(ey); mb = OPD_W'(ey); clr = 1'b0;
      end
      ST_PT0: begin
        ma = OPD_W'(wx);
        mb = deg_q ? OPD_W'(wx) : OPD_W'(wy);
        if (!deg_q) ma = OPD_W'(ex);
      end
      ST_PT1: begin
        clr = 1'b0;
        if (deg_q) begin
          ma = OPD_W'(wy); mb = OPD_W'(wy);
        end else begin
          ma = OPD_W'(ey); mb = OPD_W'(wx); sub = 1'b1;
        end
      end
      ST_C0: begin
        ma = OPD_W'(c_q[CH_W-1:26]); mb = OPD_W'(c_q[CH_W-1:26]); sh = SH_52;
      end
      ST_C1: begin
        ma = OPD_W'(c_q[CH_W-1:26]); mb = OPD_W'(c_q[25:0]); sh = SH_27; clr = 1'b0;
      end
      ST_C2: begin
        ma = OPD_W'(c_q[25:0]); mb = OPD_W'(c_q[25:0]); clr = 1'b0;
      end
      ST_C3: begin
        ma = OPD_W'(tol2_q); mb = OPD_W'(chord2_q[CH_W-1:26]);
        sh = SH_26; clr = 1'b0; sub = 1'b1;
      end
      ST_C4: begin
        ma = OPD_W'(tol2_q); mb = OPD_W'(chord2_q[25:0]); clr = 1'b0; sub = 1'b1;
      end
      default: begin
        ma = '0;
      end
    endcase
  end

  always_comb begin
    prod = ma * mb;
    pext = {{(ACC_W-PRD_W){prod[PRD_W-1]}}, prod};
    case (sh)
      SH_26:   pshift = pext <<< 26;
      SH_27:   pshift = pext <<< 27;
      SH_52:   pshift = pext <<< 52;
      default: pshift = pext;
    endcase
    acc_d = (clr ? '0 : acc_q) + (sub ? -pshift : pshift);
  end

  // Midpoint split, left half kept, right half pushed
  function automatic crd_t midp(crd_t a, crd_t b);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    return s[COORD_W:1];
  endfunction

  crd_t [3:0] lx, ly, rx, ry;
  always_comb begin
    crd_t m01, m12, m23, ma2, mb2, mm;
    for (int k = 0; k < 2; k++) begin
      crd_t c0, c1, c2, c3;
      c0 = (k == 0) ? qx_q[0] : qy_q[0];
      c1 = (k == 0) ? qx_q[1] : qy_q[1];
      c2 = (k == 0) ? qx_q[2] : qy_q[2];
      c3 = (k == 0) ? qx_q[3] : qy_q[3];
      m01 = midp(c0, c1);
      m12 = midp(c1, c2);
      m23 = midp(c2, c3);
      ma2 = midp(m01, m12);
      mb2 = midp(m12, m23);
      if (e_q == 2'd2) begin
        mm = ma2;
        if (k == 0) begin
          lx = {crd_t'(0), mm, m01, c0}; rx = {crd_t'(0), c2, m12, mm};
        end else begin
          ly = {crd_t'(0), mm, m01, c0}; ry = {crd_t'(0), c2, m12, mm};
        end
      end else begin
        mm = midp(ma2, mb2);
        if (k == 0) begin
          lx = {mm, ma2, m01, c0}; rx = {c3, m23, mb2, mm};
        end else begin
          ly = {mm, ma2, m01, c0}; ry = {c3, m23, mb2, mm};
        end
      end
    end
  end

  // Per-step decisions
  logic [ACC_W-1:0] acc_abs;
  logic             flat_p, flat_n, final_pc, emit, out_free, stall, out_load;
  always_comb begin
    acc_abs  = acc_d[ACC_W-1] ? -acc_d : acc_d;
    flat_p   = deg_q ? (acc_d <= $signed({72'd0, tol2_q})) : (acc_d <= 0);
    flat_n   = flat_q & flat_p;
    final_pc = (e_q == 2'd1) || flat_q || (lvl_q >= LVL_W'(MAX_DEPTH));
    emit     = chord2_q > CH_W'(eps2_q);
    out_free = !out_valid_q || out_ready_i;
    stall    = emit && hold_v_q && !out_free;
    out_load = ((state_q == ST_DECIDE) && final_pc && !stall && emit && hold_v_q) ||
               ((state_q == ST_DONE) && hold_v_q && out_free);
  end

  logic accept;
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.opcode == OP_MOVE || (!started_q && in_data_i.opcode <= OP_CLOSE))
            state_d = ST_DONE;
          else if (in_data_i.opcode <= OP_CLOSE)
            state_d = ST_TOL;
        end
      end
      ST_TOL:  state_d = ST_EPS;
      ST_EPS:  state_d = ST_CH0;
      ST_CH0:  state_d = ST_CH1;
      ST_CH1:  state_d = (e_q == 2'd1) ? ST_DECIDE : ST_PT0;
      ST_PT0:  state_d = ST_PT1;
      ST_PT1: begin
        if (!deg_q)
          state_d = ST_C0;
        else if (e_q == 2'd3 && !pidx_q && flat_n)
          state_d = ST_PT0;
        else
          state_d = ST_DECIDE;
      end
      ST_C0:   state_d = ST_C1;
      ST_C1:   state_d = ST_C2;
      ST_C2:   state_d = ST_C3;
      ST_C3:   state_d = ST_C4;
      ST_C4:   state_d = (e_q == 2'd3 && !pidx_q && flat_n) ? ST_PT0 : ST_DECIDE;
      ST_DECIDE: begin
        if (!final_pc)
          state_d = ST_CH0;
        else if (!stall)
          state_d = (sp_q == '0) ? ST_DONE : ST_POP;
      end
      ST_POP:  state_d = ST_CH0;
      ST_DONE: if (!hold_v_q || out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      started_q   <= 1'b0;
      sp_q        <= '0;
      lvl_q       <= '0;
      e_q         <= 2'd1;
      pidx_q      <= 1'b0;
      flat_q      <= 1'b1;
      deg_q       <= 1'b0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      tol_q       <= TOL_W'(64);
      eps_q       <= EPS_W'(1);
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      sub_x_q     <= '0;
      sub_y_q     <= '0;
    end else begin
      state_q <= state_d;
      // Load the output register or drop the transaction once taken
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TOLERANCE) tol_q <= cfg_data_i[TOL_W-1:0];
        else                            eps_q <= cfg_data_i[EPS_W-1:0];
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && in_data_i.opcode <= OP_CLOSE) begin
            sp_q   <= '0;
            lvl_q  <= '0;
            flat_q <= 1'b1;
            pidx_q <= 1'b0;
            case (in_data_i.opcode)
              OP_QUAD:  e_q <= 2'd2;
              OP_CUBIC: e_q <= 2'd3;
              default:  e_q <= 2'd1;
            endcase
            if (in_data_i.opcode == OP_MOVE) begin
              started_q <= 1'b1;
              hold_v_q  <= 1'b1;
              cur_x_q   <= in_data_i.p1_x;
              cur_y_q   <= in_data_i.p1_y;
              sub_x_q   <= in_data_i.p1_x;
              sub_y_q   <= in_data_i.p1_y;
            end else if (!started_q) begin
              hold_v_q <= 1'b1;
            end else begin
              case (in_data_i.opcode)
                OP_LINE: begin
                  cur_x_q <= in_data_i.p1_x; cur_y_q <= in_data_i.p1_y;
                end
                OP_QUAD: begin
                  cur_x_q <= in_data_i.p2_x; cur_y_q <= in_data_i.p2_y;
                end
                OP_CUBIC: begin
                  cur_x_q <= in_data_i.p3_x; cur_y_q <= in_data_i.p3_y;
                end
                default: begin
                  cur_x_q <= sub_x_q; cur_y_q <= sub_y_q;
                end
              endcase
            end
          end
        end
        ST_CH0: begin
          flat_q <= 1'b1;
          pidx_q <= 1'b0;
        end
        ST_CH1: deg_q <= acc_d <= $signed({88'd0, eps2_q});
        ST_PT1: begin
          if (deg_q) begin
            flat_q <= flat_n;
            pidx_q <= 1'b1;
          end
        end
        ST_C4: begin
          flat_q <= flat_n;
          pidx_q <= 1'b1;
        end
        ST_DECIDE: begin
          if (!final_pc) begin
            sp_q  <= sp_q + SP_W'(1);
            lvl_q <= lvl_q + LVL_W'(1);
          end else if (!stall) begin
            if (emit) hold_v_q <= 1'b1;
            if (sp_q != '0) sp_q <= sp_q - SP_W'(1);
          end
        end
        ST_POP: lvl_q <= rd_q.lvl;
        ST_DONE: begin
          if (hold_v_q && out_free) hold_v_q <= 1'b0;
        end
        default: begin
          sp_q <= sp_q;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          qx_q[0] <= cur_x_q;
          qy_q[0] <= cur_y_q;
          qx_q[1] <= (in_data_i.opcode == OP_CLOSE) ? sub_x_q : in_data_i.p1_x;
          qy_q[1] <= (in_data_i.opcode == OP_CLOSE) ? sub_y_q : in_data_i.p1_y;
          qx_q[2] <= in_data_i.p2_x;
          qy_q[2] <= in_data_i.p2_y;
          qx_q[3] <= in_data_i.p3_x;
          qy_q[3] <= in_data_i.p3_y;
          hold_q.last  <= 1'b0;
          if (in_data_i.opcode == OP_MOVE) begin
            hold_q.point_x <= in_data_i.p1_x;
            hold_q.point_y <= in_data_i.p1_y;
            hold_q.error   <= 1'b0;
          end else begin
            hold_q.point_x <= '0;
            hold_q.point_y <= '0;
            hold_q.error   <= 1'b1;
          end
        end
      end
      ST_TOL: tol2_q <= acc_d[31:0];
      ST_EPS: eps2_q <= acc_d[15:0];
      ST_CH1: chord2_q <= acc_d[CH_W-1:0];
      ST_PT1: c_q <= acc_abs[CH_W-1:0];
      ST_DECIDE: begin
        if (!final_pc) begin
          stack_mem[sp_q] <= '{lvl: lvl_q + LVL_W'(1), x: rx, y: ry};
          qx_q <= lx;
          qy_q <= ly;
        end else if (!stall) begin
          if (emit) begin
            // Held vertex is never the last one here
            if (hold_v_q) out_q <= hold_q;
            hold_q.point_x <= qe_x;
            hold_q.point_y <= qe_y;
            hold_q.last    <= 1'b0;
            hold_q.error   <= 1'b0;
          end
          if (sp_q != '0) rd_q <= stack_mem[sp_q - SP_W'(1)];
        end
      end
      ST_POP: begin
        qx_q <= rd_q.x;
        qy_q <= rd_q.y;
      end
      ST_DONE: begin
        if (hold_v_q && out_free) begin
          out_q <= '{point_x: hold_q.point_x, point_y: hold_q.point_y,
                     last: 1'b1, error: hold_q.error};
        end
      end
      default: begin
        c_q <= c_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  ap_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !hold_v_q) else $error("vertex held while idle");
  ap_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(MAX_DEPTH)) else $error("stack overflow");
  ap_lvl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LVL_W'(MAX_DEPTH)) else $error("depth beyond limit");
  ap_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> (sp_q < $past(sp_q))) else $error("pop without entry");

endmodule
